// ----- rtl/core/sc2a_pkg.sv -----
// ----------------------------------------------------------------------------
// sc2a_pkg
// Shared types, constants and keymap tables for the scancode-to-ASCII FIFO.
// ----------------------------------------------------------------------------
package sc2a_pkg;

    localparam int DEPTH = 64;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int CODE_W = 8;
    localparam int CHAR_W = 7;
    localparam int MAPPED_CODES = 58;
    localparam int MAP_IDX_W = $clog2(MAPPED_CODES);

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam int BREAK_BIT = 7;

    typedef enum logic [0:0] {
        S_IDLE,
        S_READ
    } t_state;

    typedef struct packed {
        logic scan_take;
        logic read_empty;
        logic read_pop;
    } t_dp_cmd;

    typedef struct packed {
        logic fifo_empty;
        logic out_free;
    } t_dp_status;

    localparam logic [CHAR_W-1:0] PLAIN_MAP [MAPPED_CODES] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08,
        7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F,
        7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C,
        7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F,
        7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [CHAR_W-1:0] UPPER_MAP [MAPPED_CODES] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08,
        7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F,
        7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C,
        7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F,
        7'h00, 7'h2A, 7'h00, 7'h20
    };

    function automatic logic [CHAR_W-1:0] key_lookup(
        input logic [CODE_W-1:0] code,
        input logic              shift
    );
        logic [CHAR_W-1:0]    ch;
        logic [MAP_IDX_W-1:0] idx;
        idx = code[MAP_IDX_W-1:0];
        ch  = '0;
        if (code < CODE_W'(MAPPED_CODES)) begin
            ch = shift ? UPPER_MAP[idx] : PLAIN_MAP[idx];
        end
        return ch;
    endfunction

endpackage

// ----- rtl/core/sc2a_ctrl.sv -----
// ----------------------------------------------------------------------------
// sc2a_ctrl
// Controller: input handshake and sequencing of FIFO reads into the output.
// ----------------------------------------------------------------------------
module sc2a_ctrl
    import sc2a_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_cmd,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_dp_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_accept;

    assign o_in_ready = (r_state == S_IDLE) && ((i_cmd == CMD_SCAN) || i_status.out_free);
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_cmd == CMD_READ) && !i_status.fifo_empty) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_dp_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_dp_cmd.scan_take  = in_accept && (i_cmd == CMD_SCAN);
                o_dp_cmd.read_empty = in_accept && (i_cmd == CMD_READ) && i_status.fifo_empty;
            end
            S_READ: begin
                o_dp_cmd.read_pop = i_status.out_free;
            end
            default: o_dp_cmd = '0;
        endcase
    end

endmodule

// ----- rtl/core/sc2a_dp.sv -----
// ----------------------------------------------------------------------------
// sc2a_dp
// Datapath: shift flag, keymap lookup, character store, pointers, output.
// ----------------------------------------------------------------------------
module sc2a_dp
    import sc2a_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_dp_cmd,
    output t_dp_status        o_status,
    input  logic [CODE_W-1:0] i_scancode,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_char_valid,
    output logic [CHAR_W-1:0] o_character
);

    logic [CHAR_W-1:0] r_store [DEPTH];
    logic [CHAR_W-1:0] r_rd_data;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr;
    logic              r_shift;
    logic              r_out_valid;
    logic              r_char_valid;
    logic [CHAR_W-1:0] r_character;

    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CHAR_W-1:0] map_char;
    logic              is_shift_make;
    logic              is_shift_break;
    logic              push;

    assign wr_ptr_next = (r_wr_ptr == PTR_W'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
    assign rd_ptr_next = (r_rd_ptr == PTR_W'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
    assign map_char    = key_lookup(i_scancode, r_shift);

    assign is_shift_make  = (i_scancode == SC_LSHIFT_MAKE) || (i_scancode == SC_RSHIFT_MAKE);
    assign is_shift_break = (i_scancode == SC_LSHIFT_BREAK) || (i_scancode == SC_RSHIFT_BREAK);

    assign push = i_dp_cmd.scan_take && !is_shift_make && !i_scancode[BREAK_BIT]
                  && (map_char != '0) && (wr_ptr_next != r_rd_ptr);

    assign o_status.fifo_empty = (r_rd_ptr == r_wr_ptr);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_store[r_wr_ptr] <= map_char;
        end
        r_rd_data <= r_store[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
        end else begin
            if (i_dp_cmd.scan_take && is_shift_make) begin
                r_shift <= 1'b1;
            end else if (i_dp_cmd.scan_take && is_shift_break) begin
                r_shift <= 1'b0;
            end
            if (push) begin
                r_wr_ptr <= wr_ptr_next;
            end
            if (i_dp_cmd.read_pop) begin
                r_rd_ptr <= rd_ptr_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.read_pop || i_dp_cmd.read_empty) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.read_pop) begin
            r_char_valid <= 1'b1;
            r_character  <= r_rd_data;
        end else if (i_dp_cmd.read_empty) begin
            r_char_valid <= 1'b0;
            r_character  <= '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_char_valid = r_char_valid;
    assign o_character  = r_character;

endmodule

// ----- rtl/core/scancode_to_ascii_fifo.sv -----
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo
// PS/2 set-1 scancode to ASCII converter with a character FIFO.
// ----------------------------------------------------------------------------
// Each input item is a scancode (cmd 0) or a read request (cmd 1). Shift make
// and break codes track the shift state; other make codes from 0 to 57 map
// through the plain or shifted keymap, and nonzero characters enter a ring
// FIFO that holds DEPTH-1 characters and drops new ones when full. A scancode
// gives no result. A read on an empty FIFO gives a registered result with
// char_valid 0; a read on a non-empty FIFO goes through S_READ, which pops
// the character from the store's registered read port into the output
// register once it is free. The output register holds a result until it is
// taken, while scancodes keep flowing in. No clearing pass follows reset.
module scancode_to_ascii_fifo
    import sc2a_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_cmd,
    input  logic [CODE_W-1:0] i_scancode,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_char_valid,
    output logic [CHAR_W-1:0] o_character
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    sc2a_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_dp_cmd   (dp_cmd)
    );

    sc2a_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dp_cmd     (dp_cmd),
        .o_status     (dp_status),
        .i_scancode   (i_scancode),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_char_valid (o_char_valid),
        .o_character  (o_character)
    );

endmodule
